>>> hw/rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Shared constants, status codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package qrs_pkg;
    localparam int unsigned COEF_W    = 32;
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned DISC_W    = 68;
    localparam int unsigned ROOT_W    = 34;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NEG  = 2'd1,
        ST_AZ   = 2'd2,
        ST_SAT  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SQRT,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic done;
    } unit_ctl_t;
endpackage
`default_nettype wire

>>> hw/rtl/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// Quadratic root solver square root unit
// Restoring digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module qrs_sqrt (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire qrs_pkg::unit_ctl_t          ctl_in,
    input  wire logic [qrs_pkg::DISC_W-1:0]  rad,
    output logic                             done,
    output logic [qrs_pkg::ROOT_W-1:0]       root
);
    localparam int unsigned RW = qrs_pkg::DISC_W + 2;
    logic [qrs_pkg::DISC_W-1:0] rad_reg, rad_next;
    logic [RW-1:0]              rem_reg, rem_next;
    logic [qrs_pkg::ROOT_W-1:0] q_reg, q_next;
    logic [5:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg;
    logic [RW-1:0]              trial, shifted;

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[RW-3:0], rad_reg[qrs_pkg::DISC_W-1 -: 2]};
        trial     = {{(RW-qrs_pkg::ROOT_W-2){1'b0}}, q_reg, 2'b01};
        if (ctl_in.start) begin
            rad_next  = rad;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = 6'(qrs_pkg::ROOT_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = rad_reg << 2;
            if (shifted >= trial) begin
                rem_next = shifted - trial;
                q_next   = {q_reg[qrs_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                q_next   = {q_reg[qrs_pkg::ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= busy_reg && (cnt_reg == 6'd1);
        end
    end

    assign done = done_reg;
    assign root = q_reg;
endmodule
`default_nettype wire

>>> hw/rtl/qrs_div.sv
// ----------------------------------------------------------------------------
// Quadratic root solver divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module qrs_div #(
    parameter int unsigned NUM_W = 64,
    parameter int unsigned DEN_W = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire qrs_pkg::unit_ctl_t ctl_in,
    input  wire logic [NUM_W-1:0]   num,
    input  wire logic [DEN_W-1:0]   den,
    output logic                    done,
    output logic [NUM_W-1:0]        quo
);
    localparam int unsigned CW = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   rem_reg, rem_next, sh;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg;

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        sh        = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        if (ctl_in.start) begin
            q_next    = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CW'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (sh >= {1'b0, den_reg}) begin
                rem_next = sh - {1'b0, den_reg};
                q_next   = {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = sh;
                q_next   = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= busy_reg && (cnt_reg == CW'(1));
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule
`default_nettype wire

>>> hw/rtl/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// Quadratic root solver
// Real roots of a*x^2+b*x+c=0 in signed fixed point.
//
//  channel  | ports                              | dir
//  request  | s_valid s_ready s_coef_a/b/c       | in
//  result   | m_valid m_ready m_root_plus/minus  | out
//           | m_status                           |
//
// A request runs two 32x32 products (b*b, then a*c), the bit-serial square
// root, and two passes of the shared divider, one per root. Zero a or a
// negative discriminant ends early. s_ready is high only while idle; a result
// holds until m_ready.
// Synchronous active-low reset returns the sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none
module quadratic_root_solver #(
    parameter int unsigned FRAC_BITS = qrs_pkg::FRAC_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic signed [31:0] s_coef_a,
    input  wire logic signed [31:0] s_coef_b,
    input  wire logic signed [31:0] s_coef_c,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [31:0] m_root_plus,
    output logic signed [31:0] m_root_minus,
    output logic [1:0]       m_status
);
    localparam int unsigned DW = qrs_pkg::DISC_W;

    qrs_pkg::state_t st_reg, st_next;
    logic [31:0] ma_reg, mb_reg, mc_reg;
    logic        an_reg, bn_reg, cn_reg;
    logic [1:0]  step_reg, step_next;
    logic [63:0] prod_reg;
    logic [DW-1:0] bb_reg, ac_reg;
    logic [31:0] mul_x, mul_y;
    logic [31:0] rp_reg, rm_reg;
    logic [1:0]  stat_reg;
    logic        sat_reg;
    logic        dv_neg_reg;
    qrs_pkg::unit_ctl_t sq_ctl, dv_ctl;
    logic        sq_done, dv_done;
    logic [qrs_pkg::ROOT_W-1:0] sq_root;
    logic [63:0] dv_quo, dv_num;
    logic signed [32:0] s_b_keep_s;
    logic signed [35:0] numer;
    logic [35:0] nmag;
    logic        nneg, dneg;
    logic [31:0] qsat;
    logic        qs;
    logic        disc_neg;
    logic [DW-1:0] rad;

    always_comb begin
        unique case (step_reg)
            2'd0:    begin mul_x = mb_reg; mul_y = mb_reg; end
            default: begin mul_x = ma_reg; mul_y = mc_reg; end
        endcase
    end

    assign s_b_keep_s = bn_reg ? -33'(signed'({1'b0, mb_reg})) : 33'(signed'({1'b0, mb_reg}));

    // signed numerator: -b + root before the S_DIV state, -b - root during it
    always_comb begin
        if (st_reg == qrs_pkg::S_DIV)
            numer = -36'(s_b_keep_s) - 36'(signed'({1'b0, sq_root}));
        else
            numer = -36'(s_b_keep_s) + 36'(signed'({1'b0, sq_root}));
    end

    assign nneg   = numer[35];
    assign nmag   = nneg ? 36'(-numer) : 36'(numer);
    assign dneg   = an_reg;
    assign dv_num = 64'(nmag) << FRAC_BITS;

    always_comb begin
        qs = 1'b0;
        if (dv_neg_reg) begin
            if (dv_quo > 64'h8000_0000) begin qs = 1'b1; qsat = 32'h8000_0000; end
            else qsat = 32'(-dv_quo);
        end else begin
            if (dv_quo > 64'h7FFF_FFFF) begin qs = 1'b1; qsat = 32'h7FFF_FFFF; end
            else qsat = dv_quo[31:0];
        end
    end

    assign disc_neg = !(an_reg != cn_reg || mc_reg == '0) && (ac_reg > bb_reg);

    always_comb begin
        st_next   = st_reg;
        step_next = step_reg;
        unique case (st_reg)
            qrs_pkg::S_IDLE: if (s_valid) begin
                st_next   = (s_coef_a == '0) ? qrs_pkg::S_DONE : qrs_pkg::S_MUL;
                step_next = '0;
            end
            qrs_pkg::S_MUL: begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                    st_next = disc_neg ? qrs_pkg::S_DONE : qrs_pkg::S_SQRT;
            end
            qrs_pkg::S_SQRT: if (sq_done) begin
                st_next = qrs_pkg::S_DIV;
                step_next = '0;
            end
            qrs_pkg::S_DIV: if (dv_done) begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd1) st_next = qrs_pkg::S_DONE;
            end
            qrs_pkg::S_DONE: if (m_ready) st_next = qrs_pkg::S_IDLE;
            default: st_next = qrs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = (st_reg == qrs_pkg::S_IDLE);
        m_valid      = (st_reg == qrs_pkg::S_DONE);
        sq_ctl.start = (st_reg == qrs_pkg::S_MUL) && (step_reg == 2'd3) && !disc_neg;
        sq_ctl.done  = 1'b0;
        dv_ctl.start = ((st_reg == qrs_pkg::S_SQRT) && sq_done)
                    || ((st_reg == qrs_pkg::S_DIV) && dv_done && step_reg == 2'd0);
        dv_ctl.done  = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= qrs_pkg::S_IDLE;
            step_reg <= '0;
        end else begin
            st_reg   <= st_next;
            step_reg <= step_next;
        end
        prod_reg <= mul_x * mul_y;
        if (st_reg == qrs_pkg::S_IDLE && s_valid) begin
            an_reg   <= s_coef_a[31];
            bn_reg   <= s_coef_b[31];
            cn_reg   <= s_coef_c[31];
            ma_reg   <= s_coef_a[31] ? 32'(-s_coef_a) : s_coef_a;
            mb_reg   <= s_coef_b[31] ? 32'(-s_coef_b) : s_coef_b;
            mc_reg   <= s_coef_c[31] ? 32'(-s_coef_c) : s_coef_c;
            rp_reg   <= '0;
            rm_reg   <= '0;
            stat_reg <= (s_coef_a == '0) ? qrs_pkg::ST_AZ : qrs_pkg::ST_OK;
            sat_reg  <= 1'b0;
        end
        if (st_reg == qrs_pkg::S_MUL) begin
            if (step_reg == 2'd1) bb_reg <= DW'(prod_reg);
            if (step_reg == 2'd2) begin
                ac_reg <= DW'(prod_reg) << 2;
            end
        end
        if (st_reg == qrs_pkg::S_MUL && step_reg == 2'd3 && disc_neg)
            stat_reg <= qrs_pkg::ST_NEG;
        if (dv_ctl.start) dv_neg_reg <= (nneg != dneg);
        if (st_reg == qrs_pkg::S_DIV && dv_done) begin
            if (step_reg == 2'd0) rp_reg <= qsat;
            else begin
                rm_reg   <= qsat;
                stat_reg <= (sat_reg || qs) ? qrs_pkg::ST_SAT : qrs_pkg::ST_OK;
            end
            sat_reg <= sat_reg || qs;
        end
    end

    assign rad = (an_reg != cn_reg || mc_reg == '0) ? bb_reg + ac_reg : bb_reg - ac_reg;

    qrs_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_in  (sq_ctl),
        .rad     (rad),
        .done    (sq_done),
        .root    (sq_root)
    );

    qrs_div #(.NUM_W(64), .DEN_W(33)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_in  (dv_ctl),
        .num     (dv_num),
        .den     ({ma_reg, 1'b0}),
        .done    (dv_done),
        .quo     (dv_quo)
    );

    assign m_root_plus  = rp_reg;
    assign m_root_minus = rm_reg;
    assign m_status     = stat_reg;
endmodule
`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Quadratic root solver testbench
// Drives coefficient requests through the valid/ready request channel, predicts
// each root pair and status with an exact wide-integer model, and compares
// every result in order. Covers zero a, negative discriminant, saturation,
// field extremes, random requests and back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_coef_a = '0;
    logic signed [31:0] s_coef_b = '0;
    logic signed [31:0] s_coef_c = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_root_plus;
    logic signed [31:0] m_root_minus;
    logic [1:0] m_status;

    typedef struct {
        logic [31:0] rp;
        logic [31:0] rm;
        qrs_pkg::status_t st;
    } roots_t;

    roots_t roots_q[$];
    int errors = 0;
    int send_idle = 19;
    int recv_idle = 69;
    int hold_cycles = 0;
    longint cycles = 0;

    quadratic_root_solver dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_coef_a(s_coef_a), .s_coef_b(s_coef_b), .s_coef_c(s_coef_c),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_root_plus(m_root_plus), .m_root_minus(m_root_minus),
        .m_status(m_status)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [31:0] fix_div(logic signed [67:0] num,
                                            logic signed [31:0] a, inout bit sat);
        logic [67:0] mag;
        logic [67:0] q;
        logic [31:0] am;
        bit neg;
        mag = num < 0 ? -num : num;
        am = a < 0 ? -a : a;
        mag = mag << (qrs_pkg::FRAC_BITS - 1);
        q = mag / am;
        neg = (num < 0) != (a < 0);
        if (neg) begin
            if (q > 68'h80000000) begin
                sat = 1;
                return 32'h80000000;
            end
            return -q[31:0];
        end
        if (q > 68'h7FFFFFFF) begin
            sat = 1;
            return 32'h7FFFFFFF;
        end
        return q[31:0];
    endfunction

    function automatic roots_t solve_roots(logic signed [31:0] a, logic signed [31:0] b,
                                           logic signed [31:0] c);
        roots_t r;
        logic signed [69:0] disc;
        logic [69:0] ud;
        logic [67:0] root;
        logic [67:0] t;
        bit sat;
        sat = 0;
        r.rp = '0;
        r.rm = '0;
        if (a == 0) begin
            r.st = qrs_pkg::ST_AZ;
            return r;
        end
        disc = 70'(b) * 70'(b) - 70'sd4 * 70'(a) * 70'(c);
        if (disc < 0) begin
            r.st = qrs_pkg::ST_NEG;
            return r;
        end
        ud = disc;
        root = '0;
        for (int i = 33; i >= 0; i--) begin
            t = root | (68'd1 << i);
            if (70'(t) * 70'(t) <= ud) root = t;
        end
        r.rp = fix_div(-68'(b) + $signed(root), a, sat);
        r.rm = fix_div(-68'(b) - $signed(root), a, sat);
        r.st = sat ? qrs_pkg::ST_SAT : qrs_pkg::ST_OK;
        return r;
    endfunction

    task automatic send_request(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_coef_a <= a;
        s_coef_b <= b;
        s_coef_c <= c;
        roots_q.push_back(solve_roots(a, b, c));
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(32'h0003FFFF) - 32'h00020000;
            2: return $urandom_range(32'h01FFFFFF) - 32'h01000000;
            3: return 32'h1 << $urandom_range(31);
            4: return $urandom_range(255) - 128;
            default: return $urandom_range(32'h00FFFFFF) - 32'h00800000;
        endcase
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= $urandom_range(99) >= recv_idle;
            end
        end
    end

    always @(posedge aclk) begin
        roots_t e;
        if (aresetn && m_valid && m_ready) begin
            if (roots_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h %h %0d",
                    m_root_plus, m_root_minus, m_status);
            end else begin
                e = roots_q.pop_front();
                if (m_root_plus !== e.rp || m_root_minus !== e.rm || m_status !== e.st) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %h %h %0d got %h %h %0d",
                            e.rp, e.rm, e.st, m_root_plus, m_root_minus, m_status);
                end
            end
        end
    end

    task automatic test_directed();
        send_request(32'h0, 32'h00010000, 32'h00010000);
        send_request(32'h0, 32'h0, 32'h0);
        send_request(32'h00010000, 32'h0, 32'h00010000);
        send_request(32'h00010000, 32'h0, 32'hFFFF0000);
        send_request(32'h00010000, 32'hFFFD0000, 32'h00020000);
        send_request(32'hFFFF0000, 32'h00010000, 32'h00020000);
        send_request(32'h00010000, 32'h00020000, 32'h00010000);
        send_request(32'h00000001, 32'h7FFFFFFF, 32'h0);
        send_request(32'h00000001, 32'h80000000, 32'h80000000);
        send_request(32'h80000000, 32'h80000000, 32'h7FFFFFFF);
        send_request(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_request(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        send_request(32'h7FFFFFFF, 32'h0, 32'h80000000);
        send_request(32'hFFFFFFFF, 32'h0, 32'h7FFFFFFF);
        send_request(32'h00000001, 32'h0, 32'h0);
        send_request(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_request(32'h00010000, 32'h0, 32'h0);
        send_request(32'h00000001, 32'h00000001, 32'h00000001);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_request(rand_coef(), rand_coef(), rand_coef());
    endtask

    task automatic test_backpressure();
        hold_cycles <= 800;
        test_random(6);
        s_valid <= 1'b0;
        wait (roots_q.size() == 0);
        @(posedge aclk);
        test_random(4);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(480);
        send_idle = 69;
        recv_idle = 19;
        test_backpressure();
        test_random(470);
        send_idle = 0;
        recv_idle = 0;
        test_random(480);
        s_valid <= 1'b0;
        wait (roots_q.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
